/* sv/rsort_pkg.sv */
// ----------------------------------------------------------------------------
// rsort_pkg
// shared types and constants of the two-key record sorter
// ----------------------------------------------------------------------------
`default_nettype none

package rsort_pkg;

  // default store depth
  localparam int MAX_RECORDS_DEF = 16;

  // width of the rank field on the result
  localparam int POS_W = 6;

  // write data select codes for the sort write port
  localparam logic WR_SEL_RDATA = 1'b0;
  localparam logic WR_SEL_CUR   = 1'b1;

  typedef struct packed {
    logic [7:0]         rating;
    logic signed [15:0] year;
    logic [7:0]         record_tag;
    logic               last_record;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_rating;
    logic signed [15:0] out_year;
    logic [7:0]         out_tag;
    logic [POS_W-1:0]   position;
    logic               end_of_set;
    logic               overflow;
  } out_t;

  // one stored record
  typedef struct packed {
    logic [7:0]         rating;
    logic signed [15:0] year;
    logic [7:0]         tag;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take the input record
    logic clear_set;  // start a new, empty set
    logic rd_en;      // read store at rd_addr
    logic wr_en;      // write store at wr_addr
    logic wr_sel;     // write data select
    logic cur_ld;     // carried record takes the read data
    logic emit;       // present a result next cycle
    logic emit_end;   // result is the last of the set
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic swap;    // read record goes ahead of the carried one
    logic single;  // fewer than two records stored
  } status_t;

endpackage

`default_nettype wire

/* sv/rsort_dp.sv */
// ----------------------------------------------------------------------------
// rsort_dp
// record store, carried record, key compare and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rsort_dp #(
  parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF,
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rsort_pkg::in_t                in_data,
  input  wire rsort_pkg::cmd_t               cmd,
  input  wire logic [IDX_W-1:0]              rd_addr,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire logic [rsort_pkg::POS_W-1:0]   pos,
  output rsort_pkg::status_t                 status,
  output logic [IDX_W-1:0]                   last_idx,
  output logic                               out_valid,
  output rsort_pkg::out_t                    out_data
);

  rsort_pkg::rec_t mem [MAX_RECORDS];
  rsort_pkg::rec_t rdata_r;
  rsort_pkg::rec_t cur_r;
  rsort_pkg::rec_t wr_data;
  rsort_pkg::out_t out_data_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r;
  logic             room;
  logic             we;
  logic [IDX_W-1:0] wa;

  assign room = count_r < CNT_W'(MAX_RECORDS);

  // set bookkeeping
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.clear_set) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // single write port shared by loading and sorting
  always_comb begin
    we = (cmd.load & room) | cmd.wr_en;
    wa = wr_addr;
    if (cmd.load) begin
      wa      = count_r[IDX_W-1:0];
      wr_data = '{rating: in_data.rating, year: in_data.year, tag: in_data.record_tag};
    end else if (cmd.wr_sel == rsort_pkg::WR_SEL_CUR) begin
      wr_data = cur_r;
    end else begin
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_ld) begin
      cur_r <= rdata_r;
    end
    if (cmd.emit) begin
      out_data_r <= '{out_rating: rdata_r.rating, out_year: rdata_r.year,
                      out_tag: rdata_r.tag, position: pos,
                      end_of_set: cmd.emit_end, overflow: dropped_r};
    end
  end

  // later record moves ahead: higher rating, or same rating and earlier year
  assign status.swap = (rdata_r.rating > cur_r.rating) ||
                       ((rdata_r.rating == cur_r.rating) &&
                        ($signed(rdata_r.year) < $signed(cur_r.year)));
  assign status.single = count_r < CNT_W'(2);

  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond store depth");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> (count_r == CNT_W'(MAX_RECORDS)))
    else $error("drop flagged while store has room");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.end_of_set) |-> (count_r == '0 && !dropped_r))
    else $error("set not cleared after its last result");
`endif

endmodule

`default_nettype wire

/* sv/rsort_ctrl.sv */
// ----------------------------------------------------------------------------
// rsort_ctrl
// sequencer for load, bubble passes and result readout
// ----------------------------------------------------------------------------
`default_nettype none

module rsort_ctrl #(
  parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF,
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          in_last,
  input  wire rsort_pkg::status_t            status,
  input  wire logic [IDX_W-1:0]              last_idx,
  output logic                               busy,
  output rsort_pkg::cmd_t                    cmd,
  output logic [IDX_W-1:0]                   rd_addr,
  output logic [IDX_W-1:0]                   wr_addr,
  output logic [rsort_pkg::POS_W-1:0]        pos
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;  // read first record of a pass
  localparam logic [2:0] S_LD0  = 3'd2;  // carry first record, read second
  localparam logic [2:0] S_CMP  = 3'd3;  // one compare and write per cycle
  localparam logic [2:0] S_FIN  = 3'd4;  // write carried record at the end
  localparam logic [2:0] S_ORD  = 3'd5;  // read first result
  localparam logic [2:0] S_OEM  = 3'd6;  // emit one result per cycle

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             moved_r, moved_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    moved_nxt = moved_r;
    cmd       = '0;
    rd_addr   = k_r;
    wr_addr   = k_r - IDX_W'(1);
    pos       = rsort_pkg::POS_W'(k_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (status.single) begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          state_nxt = S_LD0;
        end
      end
      S_LD0: begin
        cmd.cur_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = IDX_W'(1);
        k_nxt      = IDX_W'(1);
        moved_nxt  = 1'b0;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = status.swap ? rsort_pkg::WR_SEL_RDATA : rsort_pkg::WR_SEL_CUR;
        cmd.cur_ld = !status.swap;
        moved_nxt  = moved_r | status.swap;
        if (k_r == last_idx) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = k_r + IDX_W'(1);
          k_nxt     = k_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rsort_pkg::WR_SEL_CUR;
        wr_addr    = last_idx;
        if (moved_r) begin
          state_nxt = S_INIT;
        end else begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OEM;
      end
      S_OEM: begin
        cmd.emit = 1'b1;
        if (k_r == last_idx) begin
          cmd.emit_end  = 1'b1;
          cmd.clear_set = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = k_r + IDX_W'(1);
          k_nxt     = k_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      moved_r <= moved_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> (state_r == S_INIT))
    else $error("last record did not start the sort");

  a_end_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_end) |=> !busy)
    else $error("block still busy after the last result");

  a_no_load_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en || cmd.emit) |-> !cmd.load)
    else $error("record loaded during sort or readout");
`endif

endmodule

`default_nettype wire

/* sv/record_sorter_rating_year_core.sv */
// ----------------------------------------------------------------------------
// record_sorter_rating_year_core
// loads records, sorts a set stably by rating (high first) then year (early
// first), and reads the sorted set out one record per cycle
// ----------------------------------------------------------------------------
//
//   channel  ports                       handshake
//   -------  --------------------------  ---------------------------------
//   input    start, busy, in_data        transfer when start & !busy
//   result   out_valid, out_data         one-cycle strobe, cannot stall
//
// - a record that is not last is a one-cycle transfer; the next may follow
//   in the very next cycle
// - after the last record of a set of n (n >= 2) the block stays busy for
//   the bubble passes (1 to n) and the readout; each pass is one
//   compare-and-write per cycle on the single store write port, and passes
//   stop after the first one without a swap
// - a set of one record skips the bubble passes and goes straight to readout
// - results come out one per cycle; the last one shows while busy is low
// - synchronous active-low reset clears the controller, record count, drop
//   flag and result valid; the store needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module record_sorter_rating_year_core #(
  parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // input channel
  input  wire logic            start,
  output logic                 busy,
  input  wire rsort_pkg::in_t  in_data,
  // result channel
  output logic                 out_valid,
  output rsort_pkg::out_t      out_data
);

  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  // command and status between sequencer and datapath
  rsort_pkg::cmd_t             cmd;
  rsort_pkg::status_t          status;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic [IDX_W-1:0]            last_idx;
  logic [rsort_pkg::POS_W-1:0] pos;

  // sequencer: load, bubble passes with early exit, readout
  rsort_ctrl #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_last  (in_data.last_record),
    .status   (status),
    .last_idx (last_idx),
    .busy     (busy),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .pos      (pos)
  );

  // store, carried record, compare and result register
  rsort_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .pos       (pos),
    .status    (status),
    .last_idx  (last_idx),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
